// ===== design/fpq_pkg.sv =====
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types and constants of the frame pacer with frame queue.
// ----------------------------------------------------------------------------
package fpq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int FRAME_BYTES   = 32000;
    localparam int PALETTE_BYTES = 32;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    localparam logic [31:0] PACE_ONE = 32'd1000000;

    localparam logic [23:0] FRAME_STEP   = 24'(FRAME_BYTES);
    localparam logic [23:0] PALETTE_STEP = 24'(PALETTE_BYTES);

    localparam logic REQ_BATCH = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] BS_QUEUED  = 2'd0;
    localparam logic [1:0] BS_END     = 2'd1;
    localparam logic [1:0] BS_BAD     = 2'd2;
    localparam logic [1:0] BS_DROPPED = 2'd3;

    localparam logic [2:0] CFG_BUFFER0_BASE = 3'd0;
    localparam logic [2:0] CFG_BUFFER1_BASE = 3'd1;
    localparam logic [2:0] CFG_START_VALUE  = 3'd2;
    localparam logic [2:0] CFG_MAX_FRAMES   = 3'd3;
    localparam logic [2:0] CFG_END_CODE     = 3'd4;
    localparam logic [2:0] CFG_HIGH_RES     = 3'd5;
    localparam logic [2:0] CFG_STE_MACHINE  = 3'd6;

    localparam logic [26:0] START_VALUE_RST = 27'd2500000;

    typedef struct packed {
        logic       req_type;
        logic [7:0] frames_status;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [23:0] video_base;
        logic        write_low_byte;
        logic [23:0] palette_addr;
        logic        load_palette;
        logic [1:0]  batch_status;
        logic [4:0]  queue_level;
    } t_out;

    typedef struct packed {
        logic [23:0] buffer0_base;
        logic [23:0] buffer1_base;
        logic [26:0] start_value;
        logic [4:0]  max_frames;
        logic [7:0]  end_code;
        logic        high_res;
        logic        ste_machine;
    } t_cfg;

    typedef struct packed {
        logic        load;
        logic [26:0] value;
    } t_pace_load;

    typedef enum logic [1:0] {
        CLS_TICK = 2'd0,
        CLS_END  = 2'd1,
        CLS_BAD  = 2'd2,
        CLS_OK   = 2'd3
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [4:0]  count;
        logic [23:0] offset;
    } t_cmd;

    typedef struct packed {
        logic [23:0] screen;
        logic [23:0] palette;
    } t_entry;

endpackage

// ===== design/fpq_front.sv =====
// ----------------------------------------------------------------------------
// fpq_front
// Accepts input words, classifies them and prepares the palette offset.
// ----------------------------------------------------------------------------
module fpq_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  fpq_pkg::t_in  i_data,
    input  fpq_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output fpq_pkg::t_cmd o_cmd
);

    logic [31:0] w_offset;

    assign o_ready  = ~i_full;
    assign o_push   = i_valid & ~i_full;
    assign w_offset = 32'(i_data.frames_status[4:0]) * 32'(fpq_pkg::FRAME_BYTES);

    always_comb begin
        o_cmd.count  = i_data.frames_status[4:0];
        o_cmd.offset = w_offset[23:0];
        if (i_data.req_type == fpq_pkg::REQ_TICK) begin
            o_cmd.cls = fpq_pkg::CLS_TICK;
        end else if (i_data.frames_status == i_cfg.end_code) begin
            o_cmd.cls = fpq_pkg::CLS_END;
        end else if (i_data.frames_status == 8'd0 ||
                     i_data.frames_status > 8'(i_cfg.max_frames)) begin
            o_cmd.cls = fpq_pkg::CLS_BAD;
        end else begin
            o_cmd.cls = fpq_pkg::CLS_OK;
        end
    end

endmodule

// ===== design/fpq_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// fpq_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module fpq_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fpq_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output fpq_pkg::t_cmd o_cmd
);

    fpq_pkg::t_cmd r_buf [fpq_pkg::CMD_DEPTH];
    logic [fpq_pkg::CMD_AW-1:0] r_wp, n_wp;
    logic [fpq_pkg::CMD_AW-1:0] r_rp, n_rp;
    logic [fpq_pkg::CMD_AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (fpq_pkg::CMD_AW+1)'(fpq_pkg::CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_buf[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== design/fpq_back.sv =====
// ----------------------------------------------------------------------------
// fpq_back
// Executes commands: frame queue fill, pace counter, frame pop, result register.
// ----------------------------------------------------------------------------
module fpq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpq_pkg::t_cfg       i_cfg,
    input  fpq_pkg::t_pace_load i_pace_load,
    input  logic                i_empty,
    input  fpq_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output fpq_pkg::t_out       o_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUSH = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [fpq_pkg::PTR_W-1:0] r_head, n_head;
    logic [fpq_pkg::PTR_W-1:0] r_tail, n_tail;
    logic [fpq_pkg::CNT_W-1:0] r_qcount, n_qcount;
    logic [31:0]               r_pace, n_pace;
    logic                      r_bsel, n_bsel;
    logic [23:0]               r_screen, n_screen;
    logic [23:0]               r_pal, n_pal;
    logic [4:0]                r_left, n_left;
    fpq_pkg::t_out             r_res, n_res;
    fpq_pkg::t_out             r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    fpq_pkg::t_entry r_mem [fpq_pkg::QUEUE_DEPTH];
    fpq_pkg::t_entry r_rd;
    logic            w_we;

    logic [31:0] w_diff;
    logic [23:0] w_base;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign w_diff  = r_pace - fpq_pkg::PACE_ONE;
    assign w_base  = (~r_bsel) ? i_cfg.buffer1_base : i_cfg.buffer0_base;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_qcount    = r_qcount;
        n_pace      = r_pace;
        n_bsel      = r_bsel;
        n_screen    = r_screen;
        n_pal       = r_pal;
        n_left      = r_left;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_ready;
        w_we        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                n_res = '0;
                n_res.result_kind = fpq_pkg::KIND_STATUS;
                if (!i_empty) begin
                    unique case (i_cmd.cls)
                        fpq_pkg::CLS_TICK: begin
                            if (r_qcount != '0) begin
                                n_pace = w_diff;
                                if (w_diff < fpq_pkg::PACE_ONE) begin
                                    n_state = S_READ;
                                end
                            end
                        end
                        fpq_pkg::CLS_END: begin
                            n_bsel = ~r_bsel;
                            n_res.batch_status = fpq_pkg::BS_END;
                            n_state = S_EMIT;
                        end
                        fpq_pkg::CLS_BAD: begin
                            n_bsel = ~r_bsel;
                            n_res.batch_status = fpq_pkg::BS_BAD;
                            n_state = S_EMIT;
                        end
                        fpq_pkg::CLS_OK: begin
                            n_bsel   = ~r_bsel;
                            n_screen = w_base;
                            n_pal    = w_base + i_cmd.offset;
                            n_left   = i_cmd.count;
                            n_state  = S_PUSH;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                if (r_qcount == fpq_pkg::CNT_FULL) begin
                    n_res.batch_status = fpq_pkg::BS_DROPPED;
                    n_state = S_EMIT;
                end else begin
                    w_we     = 1'b1;
                    n_tail   = (r_tail == fpq_pkg::PTR_LAST) ? '0 : r_tail + 1'b1;
                    n_qcount = r_qcount + 1'b1;
                    n_screen = r_screen + fpq_pkg::FRAME_STEP;
                    n_pal    = r_pal + fpq_pkg::PALETTE_STEP;
                    n_left   = r_left - 1'b1;
                    if (r_left == 5'd1) begin
                        n_res.batch_status = fpq_pkg::BS_QUEUED;
                        n_state = S_EMIT;
                    end
                end
            end
            S_READ: begin
                n_pace   = r_pace + 32'(i_cfg.start_value);
                n_head   = (r_head == fpq_pkg::PTR_LAST) ? '0 : r_head + 1'b1;
                n_qcount = r_qcount - 1'b1;
                if (r_rd.screen == '0 || r_rd.palette == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_res.result_kind    = fpq_pkg::KIND_FRAME;
                    n_res.video_base     = r_rd.screen;
                    n_res.write_low_byte = i_cfg.ste_machine;
                    n_res.palette_addr   = r_rd.palette;
                    n_res.load_palette   = ~i_cfg.high_res;
                    n_res.batch_status   = fpq_pkg::BS_QUEUED;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out             = r_res;
                    n_out.queue_level = 5'(r_qcount);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_pace_load.load) begin
            n_pace = 32'(i_pace_load.value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_qcount    <= '0;
            r_pace      <= 32'(fpq_pkg::START_VALUE_RST);
            r_bsel      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_qcount    <= n_qcount;
            r_pace      <= n_pace;
            r_bsel      <= n_bsel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_screen <= n_screen;
        r_pal    <= n_pal;
        r_left   <= n_left;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_tail] <= {r_screen, r_pal};
        end
        r_rd <= r_mem[r_head];
    end

endmodule

// ===== design/frame_pacer_with_queue_core.sv =====
// ----------------------------------------------------------------------------
// frame_pacer_with_queue_core
// Frame pacer: batches fill a frame queue, blank ticks pop it at a set pace.
// ----------------------------------------------------------------------------
// Input words pass the front classifier into a four-entry command queue, so
// the input side keeps accepting while the back end works, until that queue
// fills. The back end runs one command at a time. A blank tick with frames
// queued lowers the pace counter; when a pop is due it reads the frame queue
// and shows the frame or drops an entry with a zero address. A batch pushes
// its frames one by one through the single write port of the frame queue,
// stopping if it fills, then hands off its status; an end code or bad count
// pushes none. A result then waits in the output register until taken.
// ----------------------------------------------------------------------------
module frame_pacer_with_queue_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fpq_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output fpq_pkg::t_out o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [26:0]   i_cfg_data
);

    fpq_pkg::t_cfg       r_cfg, n_cfg;
    fpq_pkg::t_pace_load w_pace_load;
    fpq_pkg::t_cmd       w_push_cmd;
    fpq_pkg::t_cmd       w_pop_cmd;
    logic                w_push;
    logic                w_full;
    logic                w_pop;
    logic                w_empty;
    logic                w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;

    assign w_pace_load.load  = w_cfg_we && (i_cfg_index == fpq_pkg::CFG_START_VALUE);
    assign w_pace_load.value = i_cfg_data;

    always_comb begin
        n_cfg = r_cfg;
        if (w_cfg_we) begin
            unique case (i_cfg_index)
                fpq_pkg::CFG_BUFFER0_BASE: n_cfg.buffer0_base = i_cfg_data[23:0];
                fpq_pkg::CFG_BUFFER1_BASE: n_cfg.buffer1_base = i_cfg_data[23:0];
                fpq_pkg::CFG_START_VALUE:  n_cfg.start_value  = i_cfg_data;
                fpq_pkg::CFG_MAX_FRAMES:   n_cfg.max_frames   = i_cfg_data[4:0];
                fpq_pkg::CFG_END_CODE:     n_cfg.end_code     = i_cfg_data[7:0];
                fpq_pkg::CFG_HIGH_RES:     n_cfg.high_res     = i_cfg_data[0];
                fpq_pkg::CFG_STE_MACHINE:  n_cfg.ste_machine  = i_cfg_data[0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer0_base <= '0;
            r_cfg.buffer1_base <= '0;
            r_cfg.start_value  <= fpq_pkg::START_VALUE_RST;
            r_cfg.max_frames   <= 5'd1;
            r_cfg.end_code     <= 8'hff;
            r_cfg.high_res     <= 1'b0;
            r_cfg.ste_machine  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    fpq_front u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    fpq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_pop_cmd)
    );

    fpq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pace_load (w_pace_load),
        .i_empty     (w_empty),
        .i_cmd       (w_pop_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks frame_pacer_with_queue_core against an in-bench predictor. Batch and
// blank tick words go in with bursty valid. The report port stalls on its own
// pattern. Each frame and batch report is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES   = 64;
    localparam int RANDOM_PHASES   = 5;
    localparam int WORDS_PER_PHASE = 150;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    fpq_pkg::t_in   i_data;
    logic           o_valid;
    logic           i_ready;
    fpq_pkg::t_out  o_data;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [26:0]    i_cfg_data;

    frame_pacer_with_queue_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // pacer state as seen from outside
    fpq_pkg::t_cfg m_cfg;
    logic [23:0]   m_screen  [fpq_pkg::QUEUE_DEPTH];
    logic [23:0]   m_palette [fpq_pkg::QUEUE_DEPTH];
    int unsigned   m_head;
    int unsigned   m_tail;
    int unsigned   m_count;
    logic [31:0]   m_pace;
    logic          m_buf_sel;
    logic          m_stream_end;

    fpq_pkg::t_out pacer_reports[$];
    fpq_pkg::t_out want_rpt;
    int            n_mismatch = 0;
    int            burst_left = 1;
    int unsigned   stall_phase = 0;
    int unsigned   stall_period = 1;
    int unsigned   stall_duty = 1;

    task automatic pacer_reset();
        m_cfg.buffer0_base = '0;
        m_cfg.buffer1_base = '0;
        m_cfg.start_value  = fpq_pkg::START_VALUE_RST;
        m_cfg.max_frames   = 5'd1;
        m_cfg.end_code     = 8'hFF;
        m_cfg.high_res     = 1'b0;
        m_cfg.ste_machine  = 1'b0;
        m_head       = 0;
        m_tail       = 0;
        m_count      = 0;
        m_pace       = {5'd0, fpq_pkg::START_VALUE_RST};
        m_buf_sel    = 1'b1;
        m_stream_end = 1'b0;
    endtask

    task automatic advance_pacer(input fpq_pkg::t_in w);
        fpq_pkg::t_out rpt;
        logic [23:0]   base;
        logic [23:0]   scr;
        logic [23:0]   pal;
        int            n;
        int            k;
        rpt = '0;
        rpt.result_kind = fpq_pkg::KIND_STATUS;
        if (w.req_type == fpq_pkg::REQ_BATCH) begin
            m_buf_sel = ~m_buf_sel;
            base = m_buf_sel ? m_cfg.buffer1_base : m_cfg.buffer0_base;
            n = w.frames_status;
            if (w.frames_status == m_cfg.end_code) begin
                m_stream_end = 1'b1;
                rpt.batch_status = fpq_pkg::BS_END;
            end else if (n < 1 || n > m_cfg.max_frames) begin
                rpt.batch_status = fpq_pkg::BS_BAD;
            end else begin
                rpt.batch_status = fpq_pkg::BS_QUEUED;
                scr = base;
                pal = base + 24'(n * fpq_pkg::FRAME_BYTES);
                k = 0;
                while (k < n && m_count < fpq_pkg::QUEUE_DEPTH) begin
                    m_screen[m_tail]  = scr;
                    m_palette[m_tail] = pal;
                    m_tail = (m_tail + 1) % fpq_pkg::QUEUE_DEPTH;
                    m_count++;
                    scr = scr + fpq_pkg::FRAME_STEP;
                    pal = pal + fpq_pkg::PALETTE_STEP;
                    k++;
                end
                if (k < n) begin
                    rpt.batch_status = fpq_pkg::BS_DROPPED;
                end
            end
            rpt.queue_level = 5'(m_count);
            pacer_reports.push_back(rpt);
        end else if (m_count != 0) begin
            m_pace = m_pace - fpq_pkg::PACE_ONE;
            if (m_pace < fpq_pkg::PACE_ONE) begin
                m_pace = m_pace + {5'd0, m_cfg.start_value};
                scr = m_screen[m_head];
                pal = m_palette[m_head];
                m_head = (m_head + 1) % fpq_pkg::QUEUE_DEPTH;
                m_count--;
                if (scr != '0 && pal != '0) begin
                    rpt.result_kind    = fpq_pkg::KIND_FRAME;
                    rpt.video_base     = scr;
                    rpt.write_low_byte = m_cfg.ste_machine;
                    rpt.palette_addr   = pal;
                    rpt.load_palette   = ~m_cfg.high_res;
                    rpt.batch_status   = fpq_pkg::BS_QUEUED;
                    rpt.queue_level    = 5'(m_count);
                    pacer_reports.push_back(rpt);
                end
            end
        end
    endtask

    function automatic fpq_pkg::t_in batch_word(input logic [7:0] status);
        fpq_pkg::t_in w;
        w.req_type      = fpq_pkg::REQ_BATCH;
        w.frames_status = status;
        return w;
    endfunction

    function automatic fpq_pkg::t_in tick_word();
        fpq_pkg::t_in w;
        w.req_type      = fpq_pkg::REQ_TICK;
        w.frames_status = 8'($urandom);
        return w;
    endfunction

    function automatic logic [23:0] pick_base();
        case ($urandom_range(0, 3))
            0: return 24'h0;
            1: return 24'h0 - 24'(fpq_pkg::FRAME_BYTES * $urandom_range(1, 3));
            2: return {16'($urandom), 8'h00};
            default: return 24'($urandom);
        endcase
    endfunction

    // one word, then maybe a gap before the next burst
    task automatic send_word(input fpq_pkg::t_in w);
        int gap;
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        advance_pacer(w);
        burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 20);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle_pacer();
        i_valid <= 1'b0;
        while (pacer_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [26:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fpq_pkg::CFG_BUFFER0_BASE: m_cfg.buffer0_base = val[23:0];
            fpq_pkg::CFG_BUFFER1_BASE: m_cfg.buffer1_base = val[23:0];
            fpq_pkg::CFG_START_VALUE: begin
                m_cfg.start_value = val;
                m_pace = {5'd0, val};
            end
            fpq_pkg::CFG_MAX_FRAMES: m_cfg.max_frames = val[4:0];
            fpq_pkg::CFG_END_CODE: m_cfg.end_code = val[7:0];
            fpq_pkg::CFG_HIGH_RES: m_cfg.high_res = val[0];
            fpq_pkg::CFG_STE_MACHINE: m_cfg.ste_machine = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [23:0] b0, input logic [23:0] b1,
                                input logic [26:0] sv, input logic [4:0] mf,
                                input logic [7:0] ec, input logic hr, input logic ste);
        settle_pacer();
        write_reg(fpq_pkg::CFG_BUFFER0_BASE, 27'(b0));
        write_reg(fpq_pkg::CFG_BUFFER1_BASE, 27'(b1));
        write_reg(fpq_pkg::CFG_START_VALUE, sv);
        write_reg(fpq_pkg::CFG_MAX_FRAMES, 27'(mf));
        write_reg(fpq_pkg::CFG_END_CODE, 27'(ec));
        write_reg(fpq_pkg::CFG_HIGH_RES, 27'(hr));
        write_reg(fpq_pkg::CFG_STE_MACHINE, 27'(ste));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic cmp_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
        if (got !== want) begin
            n_mismatch++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // reset register values: empty tick, bad counts, end code, zero entry
    task automatic test_reset_values();
        send_word(tick_word());
        send_word(batch_word(8'd0));
        send_word(batch_word(8'hFF));
        send_word(batch_word(8'd2));
        send_word(batch_word(8'd1));
        repeat (3) send_word(tick_word());
    endtask

    // full queue, partial drop, end code inside count range, address wrap
    task automatic test_queue_limits();
        program_regs(24'hFFFFFF, 24'hFF8300, 27'd1000000, 5'd16, 8'd3, 1'b1, 1'b1);
        send_word(batch_word(8'd3));
        send_word(batch_word(8'd15));
        send_word(batch_word(8'd2));
        send_word(batch_word(8'd1));
        send_word(batch_word(8'd255));
        repeat (4) send_word(tick_word());
    endtask

    // slowest pace and a zero frame limit
    task automatic test_extreme_pace();
        program_regs(24'h000100, 24'h7FFF00, 27'd100000000, 5'd0, 8'hFF, 1'b0, 1'b0);
        send_word(batch_word(8'd1));
        repeat (3) send_word(tick_word());
    endtask

    task automatic test_random_traffic();
        fpq_pkg::t_in w;
        int           n_done;
        int           sel;
        int           hi;
        logic [26:0]  sv;
        logic [4:0]   mf;
        logic [7:0]   ec;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            sv = (ph == 0) ? 27'd1000000 :
                 (ph == 1) ? 27'd100000000 : 27'($urandom_range(1000000, 4000000));
            mf = (ph == 0) ? 5'd16 : 5'($urandom_range(1, 16));
            ec = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom);
            program_regs(pick_base(), pick_base(), sv, mf, ec,
                         1'($urandom), 1'($urandom));
            n_done = 0;
            while (n_done < WORDS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 80) begin
                    w = tick_word();
                end else begin
                    sel = $urandom_range(0, 9);
                    hi  = (sel < 6 && m_cfg.max_frames > 3) ? 3 : int'(m_cfg.max_frames);
                    if (sel == 0) begin
                        w = batch_word(m_cfg.end_code);
                    end else if (sel == 1 || hi == 0) begin
                        w = batch_word(8'($urandom));
                    end else begin
                        w = batch_word(8'($urandom_range(1, hi)));
                    end
                end
                n_done++;
                send_word(w);
            end
        end
    endtask

    // report port: compare each word, stall on a shifting duty pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pacer_reports.size() == 0) begin
                    n_mismatch++;
                    $display("%0t: word expected none actual %h", $time, o_data);
                end else begin
                    want_rpt = pacer_reports.pop_front();
                    cmp_field("result_kind", 24'(want_rpt.result_kind),
                              24'(o_data.result_kind));
                    cmp_field("video_base", want_rpt.video_base, o_data.video_base);
                    cmp_field("write_low_byte", 24'(want_rpt.write_low_byte),
                              24'(o_data.write_low_byte));
                    cmp_field("palette_addr", want_rpt.palette_addr, o_data.palette_addr);
                    cmp_field("load_palette", 24'(want_rpt.load_palette),
                              24'(o_data.load_palette));
                    cmp_field("batch_status", 24'(want_rpt.batch_status),
                              24'(o_data.batch_status));
                    cmp_field("queue_level", 24'(want_rpt.queue_level),
                              24'(o_data.queue_level));
                end
            end
            if (stall_phase + 1 >= stall_period) begin
                stall_phase  = 0;
                stall_period = $urandom_range(1, 24);
                stall_duty   = ($urandom_range(0, 2) == 0) ? stall_period :
                               $urandom_range(1, stall_period);
            end else begin
                stall_phase++;
            end
            i_ready <= (stall_phase < stall_duty);
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        pacer_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_queue_limits();
        test_extreme_pace();
        test_random_traffic();
        settle_pacer();
        if (n_mismatch == 0 && pacer_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
